// ===== hw/rtl/sbce_pkg.sv =====
// Package for the serial boot command engine.
// Holds the shared constants, codes, state types and the job descriptor.
// Has no dependencies; every file of the block but sbce_if imports it.
package sbce_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int NW = $clog2(MAX_PAYLOAD + 1);
    localparam int IW = $clog2(MAX_PAYLOAD);
    // The job queue depth must be a power of two.
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);
    localparam int HDR_WORDS = 8;

    localparam logic [7:0] HDR_LEN      = 8'h03;
    localparam logic [7:0] CMD_PING     = 8'h20;
    localparam logic [7:0] CMD_DOWNLOAD = 8'h21;
    localparam logic [7:0] CMD_STATUS   = 8'h23;
    localparam logic [7:0] CMD_SEND     = 8'h24;
    localparam logic [7:0] CMD_RESET    = 8'h25;
    localparam logic [7:0] ACK_CODE     = 8'hCC;
    localparam logic [7:0] NAK_CODE     = 8'h33;
    localparam logic [7:0] ST_OK        = 8'h40;
    localparam logic [7:0] ST_UNKNOWN   = 8'h41;
    localparam logic [7:0] ST_BAD_ARG   = 8'h42;
    localparam logic [7:0] ST_RANGE     = 8'h43;
    localparam logic [7:0] ST_FLASH     = 8'h44;

    typedef enum logic [1:0] {
        KIND_TX, KIND_ERASE, KIND_WRITE, KIND_RESET
    } t_kind;

    typedef enum logic [3:0] {
        PH_HELLO_LEN, PH_HELLO_SUM, PH_HELLO_CMD, PH_LEN, PH_SUM, PH_CMD,
        PH_DATA, PH_STATUS_WAIT, PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        OP_ACK, OP_NAK, OP_PING, OP_DL, OP_STATUS, OP_SEND, OP_RESET, OP_UNKNOWN
    } t_op;

    typedef enum logic [3:0] {
        B_IDLE, B_ERASE, B_WRITE, B_TX0, B_TX1, B_TXC, B_ST3, B_STA, B_STB, B_RST
    } t_bstate;

    typedef struct packed {
        t_op             op;
        logic            ok;
        logic [NW-1:0]   n;
        logic [31:0]     w0;
        logic [31:0]     w1;
    } t_job;

endpackage

// ===== hw/rtl/sbce_if.sv =====
// Channel interfaces of the serial boot command engine.
// Received bytes, result beats and configuration writes; no dependencies.
interface sbce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       flash_ok;
    modport source (output valid, output rx_byte, output flash_ok, input ready);
    modport sink (input valid, input rx_byte, input flash_ok, output ready);
endinterface

interface sbce_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [31:0] out_addr;
    logic [31:0] out_len;
    logic        out_last;
    modport source (output valid, output out_kind, output out_byte, output out_addr,
                    output out_len, output out_last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input out_addr,
                  input out_len, input out_last, output ready);
endinterface

interface sbce_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sbce_queue.sv =====
// Small job queue between the packet front end and the command back end.
// Depends on sbce_pkg for the job descriptor and the queue depth.
module sbce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbce_pkg::t_job i_job,
    input  logic          i_pop,
    output sbce_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import sbce_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr;
    logic [QAW-1:0]  r_rd;
    logic [QCW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd];
    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== hw/rtl/sbce_front.sv =====
// Front end: hello sync, packet deframing, checksum and command decode.
// Depends on sbce_pkg and sbce_if; produces jobs and holds the payload buffer.
module sbce_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sbce_in_if.sink        i_in,
    input  logic           i_q_full,
    input  logic           i_buf_busy,
    input  logic [sbce_pkg::IW-1:0] i_rd_idx,
    output logic [7:0]     o_rd_data,
    output logic           o_push,
    output sbce_pkg::t_job o_job
);
    import sbce_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_acc, n_acc;
    logic [63:0] r_w, n_w;
    logic [7:0]  r_buf [MAX_PAYLOAD];

    logic        accept;
    logic [7:0]  b;
    logic        fin;
    logic        hello_ack;
    logic [7:0]  fin_cmd;
    logic [7:0]  fin_s;
    logic [63:0] fin_w;
    logic [7:0]  pay_n;
    logic        good;
    t_op         fin_op;

    assign b        = i_in.rx_byte;
    assign i_in.ready = !i_q_full && !((r_phase == PH_DATA) && i_buf_busy);
    assign accept   = i_in.valid && i_in.ready;
    assign pay_n    = r_len - HDR_LEN;

    // Decode of the beat that completes a frame or the hello sync.
    always_comb begin
        fin       = 1'b0;
        hello_ack = 1'b0;
        fin_cmd   = r_cmd;
        fin_s     = r_acc;
        fin_w     = r_w;
        if (accept) begin
            unique case (r_phase)
                PH_HELLO_CMD: begin
                    hello_ack = (b == CMD_PING);
                end
                PH_CMD: begin
                    fin_cmd = b;
                    fin_s   = b;
                    fin     = (r_len == HDR_LEN);
                end
                PH_DATA: begin
                    fin_s = r_acc + b;
                    if (r_count < 8'(HDR_WORDS)) begin
                        fin_w = {r_w[55:0], b};
                    end
                    fin = ({1'b0, r_count} + 9'd1) >= {1'b0, pay_n};
                end
                default: begin
                    fin = 1'b0;
                end
            endcase
        end
        good = (pay_n <= 8'(MAX_PAYLOAD)) && (fin_s == r_sum);
        if (!good) begin
            fin_op = OP_NAK;
        end else begin
            unique case (fin_cmd)
                CMD_PING:     fin_op = OP_PING;
                CMD_DOWNLOAD: fin_op = OP_DL;
                CMD_STATUS:   fin_op = OP_STATUS;
                CMD_SEND:     fin_op = OP_SEND;
                CMD_RESET:    fin_op = OP_RESET;
                default:      fin_op = OP_UNKNOWN;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_sum   = r_sum;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_acc   = r_acc;
        n_w     = r_w;
        if (accept) begin
            unique case (r_phase)
                PH_HELLO_LEN: begin
                    if (b == HDR_LEN) begin
                        n_phase = PH_HELLO_SUM;
                    end
                end
                PH_HELLO_SUM: begin
                    n_phase = (b == CMD_PING) ? PH_HELLO_CMD : PH_HELLO_LEN;
                end
                PH_HELLO_CMD: begin
                    n_phase = hello_ack ? PH_LEN : PH_HELLO_LEN;
                end
                PH_LEN: begin
                    if (b >= HDR_LEN) begin
                        n_len   = b;
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_sum   = b;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    n_cmd   = b;
                    n_count = '0;
                    n_acc   = b;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_count = r_count + 8'd1;
                    n_acc   = fin_s;
                    n_w     = fin_w;
                end
                PH_STATUS_WAIT: begin
                    if (b != 8'h00) begin
                        n_phase = PH_LEN;
                    end
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
            if (fin) begin
                if (fin_op == OP_STATUS) begin
                    n_phase = PH_STATUS_WAIT;
                end else if (fin_op == OP_RESET) begin
                    n_phase = PH_HALT;
                end else begin
                    n_phase = PH_LEN;
                end
            end
        end
    end

    // Job output.
    always_comb begin
        o_push   = fin || hello_ack;
        o_job.op = hello_ack ? OP_ACK : fin_op;
        o_job.ok = i_in.flash_ok;
        o_job.n  = pay_n[NW-1:0];
        o_job.w0 = fin_w[63:32];
        o_job.w1 = fin_w[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HELLO_LEN;
            r_len   <= '0;
            r_sum   <= '0;
            r_cmd   <= '0;
            r_count <= '0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_cmd   <= n_cmd;
            r_count <= n_count;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (accept && (r_phase == PH_DATA) && (r_count < 8'(MAX_PAYLOAD))) begin
            r_buf[r_count[IW-1:0]] <= b;
        end
    end

    assign o_rd_data = r_buf[i_rd_idx];

endmodule

// ===== hw/rtl/sbce_back.sv =====
// Back end: runs queued jobs, emits one result beat per cycle when not stalled.
// Depends on sbce_pkg and sbce_if; reads the payload buffer of the front end.
module sbce_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_app_start_addr,
    input  sbce_pkg::t_job i_job,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_writing,
    output logic [sbce_pkg::IW-1:0] o_rd_idx,
    input  logic [7:0]     i_rd_data,
    sbce_out_if.source     o_out
);
    import sbce_pkg::*;

    t_bstate       r_state, n_state;
    t_job          r_job, n_job;
    logic [7:0]    r_status, n_status;
    logic [7:0]    r_code, n_code;
    logic [31:0]   r_next_addr, n_next_addr;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_wr_addr, n_wr_addr;
    logic [NW-1:0] r_idx, n_idx;

    logic          r_valid;
    t_kind         r_kind;
    logic [7:0]    r_byte;
    logic [31:0]   r_addr;
    logic [31:0]   r_olen;
    logic          r_last;

    logic          load;
    logic          emit;
    t_kind         e_kind;
    logic [7:0]    e_byte;
    logic [31:0]   e_addr;
    logic [31:0]   e_len;
    logic          e_last;
    logic          fits;

    assign load      = !r_valid || o_out.ready;
    assign o_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign o_writing = (r_state == B_WRITE);
    assign o_rd_idx  = r_idx[IW-1:0];
    assign fits      = r_rem >= 32'(i_job.n);

    // Next state.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_status    = r_status;
        n_code      = r_code;
        n_next_addr = r_next_addr;
        n_rem       = r_rem;
        n_wr_addr   = r_wr_addr;
        n_idx       = r_idx;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_job   = i_job;
                    n_code  = (i_job.op == OP_NAK) ? NAK_CODE : ACK_CODE;
                    n_state = B_TX0;
                    case (i_job.op)
                        OP_PING: n_status = ST_OK;
                        OP_UNKNOWN: n_status = ST_UNKNOWN;
                        OP_DL: begin
                            if (i_job.n != NW'(HDR_WORDS)) begin
                                n_status = ST_BAD_ARG;
                                n_rem    = '0;
                            end else if (i_job.w0 != '0) begin
                                n_next_addr = i_job.w0;
                                n_status    = ST_BAD_ARG;
                                n_rem       = '0;
                            end else begin
                                n_next_addr = i_app_start_addr;
                                n_status    = i_job.ok ? ST_OK : ST_FLASH;
                                n_rem       = i_job.ok ? i_job.w1 : '0;
                                n_state     = B_ERASE;
                            end
                        end
                        OP_SEND: begin
                            n_wr_addr = r_next_addr;
                            n_idx     = '0;
                            if (!fits) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_status = i_job.ok ? ST_OK : ST_FLASH;
                                if (i_job.ok) begin
                                    n_rem       = r_rem - 32'(i_job.n);
                                    n_next_addr = r_next_addr + 32'(i_job.n);
                                end
                                if (i_job.n != '0) begin
                                    n_state = B_WRITE;
                                end
                            end
                        end
                        default: n_status = r_status;
                    endcase
                end
            end
            B_ERASE: if (load) n_state = B_TX0;
            B_WRITE: begin
                if (load) begin
                    n_idx     = r_idx + 1'b1;
                    n_wr_addr = r_wr_addr + 32'd1;
                    if (r_idx == r_job.n - 1'b1) begin
                        n_state = B_TX0;
                    end
                end
            end
            B_TX0: if (load) n_state = B_TX1;
            B_TX1: if (load) n_state = B_TXC;
            B_TXC: begin
                if (load) begin
                    if (r_job.op == OP_STATUS) begin
                        n_state = B_ST3;
                    end else if (r_job.op == OP_RESET) begin
                        n_state = B_RST;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_ST3: if (load) n_state = B_STA;
            B_STA: if (load) n_state = B_STB;
            B_STB: if (load) n_state = B_IDLE;
            B_RST: if (load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Result of the current state.
    always_comb begin
        emit   = 1'b1;
        e_kind = KIND_TX;
        e_byte = '0;
        e_addr = '0;
        e_len  = '0;
        e_last = 1'b0;
        unique case (r_state)
            B_IDLE: emit = 1'b0;
            B_ERASE: begin
                e_kind = KIND_ERASE;
                e_addr = r_next_addr;
                e_len  = r_job.w1;
            end
            B_WRITE: begin
                e_kind = KIND_WRITE;
                e_byte = i_rd_data;
                e_addr = r_wr_addr;
            end
            B_TX0, B_TX1: e_byte = '0;
            B_TXC: begin
                e_byte = r_code;
                e_last = !((r_job.op == OP_STATUS) || (r_job.op == OP_RESET));
            end
            B_ST3: e_byte = HDR_LEN;
            B_STA: e_byte = r_status;
            B_STB: begin
                e_byte = r_status;
                e_last = 1'b1;
            end
            B_RST: begin
                e_kind = KIND_RESET;
                e_last = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_status    <= ST_OK;
            r_next_addr <= 32'hFFFF_FFFF;
            r_rem       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_next_addr <= n_next_addr;
            r_rem       <= n_rem;
            if (load) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_code    <= n_code;
        r_wr_addr <= n_wr_addr;
        r_idx     <= n_idx;
        if (load && emit) begin
            r_kind <= e_kind;
            r_byte <= e_byte;
            r_addr <= e_addr;
            r_olen <= e_len;
            r_last <= e_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_kind = r_kind;
    assign o_out.out_byte = r_byte;
    assign o_out.out_addr = r_addr;
    assign o_out.out_len  = r_olen;
    assign o_out.out_last = r_last;

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WRITE) |-> (r_idx < r_job.n))
        else $error("write index beyond payload length");
    a_erase_only_dl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_ERASE) |-> (r_job.op == OP_DL))
        else $error("erase issued for a job other than download");
    a_pop_starts_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != B_IDLE))
        else $error("job taken from queue but not started");
`endif

endmodule

// ===== hw/rtl/serial_boot_command_engine.sv =====
// Serial boot command engine: a job passes the job queue, the back end state register and
// the result register before its first result, later while earlier jobs drain. A handled
// packet then produces one result beat per cycle while the receiver is ready: up to 35 for
// send-data. Throughput is one received beat per cycle, set by the front end deframer;
// a full two-entry job queue stalls all beats, queued jobs or writes stall payload beats.
// Reset is synchronous: hello sync restarts, status 0x40, next address all ones.
// Depends on sbce_pkg, sbce_if, sbce_queue, sbce_front and sbce_back.
module serial_boot_command_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbce_in_if.sink    i_in,
    sbce_cfg_if.sink   i_cfg,
    sbce_out_if.source o_out
);
    import sbce_pkg::*;

    logic [31:0]   r_app_start_addr;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic          writing;
    t_job          push_job;
    t_job          head_job;
    logic [IW-1:0] rd_idx;
    logic [7:0]    rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_start_addr <= '0;
        end else if (i_cfg.valid) begin
            r_app_start_addr <= i_cfg.data;
        end
    end

    sbce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .i_buf_busy (writing || !q_empty),
        .i_rd_idx   (rd_idx),
        .o_rd_data  (rd_data),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    sbce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sbce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_app_start_addr (r_app_start_addr),
        .i_job            (head_job),
        .i_q_empty        (q_empty),
        .o_pop            (q_pop),
        .o_writing        (writing),
        .o_rd_idx         (rd_idx),
        .i_rd_data        (rd_data),
        .o_out            (o_out)
    );

endmodule

// ===== verif/serial_boot_command_engine_tb.sv =====
// Testbench for the serial boot command engine: drives received bytes and start addresses,
// predicts every result beat in a behavioural model of the protocol and compares them in order.
// Depends on sbce_pkg, sbce_if and the engine RTL.
`timescale 1ns / 100ps
module serial_boot_command_engine_tb;
    import sbce_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [31:0] len;
        logic        last;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sbce_in_if  rx_ch ();
    sbce_cfg_if cfg_ch ();
    sbce_out_if res_ch ();

    serial_boot_command_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(rx_ch.sink), .i_cfg(cfg_ch.sink),
        .o_out(res_ch.source)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Protocol model state.
    t_phase      m_phase;
    logic [7:0]  m_len, m_sum, m_cmd, m_cnt, m_status;
    logic [7:0]  m_buf [MAX_PAYLOAD];
    logic [31:0] m_start, m_addr, m_remain;
    t_beat       pending_beats [$];
    t_beat       step_beats [$];
    int errors = 0;
    int cycles = 0;
    int sent = 0;
    int beats_seen = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void push(input t_kind k, input logic [7:0] d,
                                 input logic [31:0] a, input logic [31:0] l);
        t_beat b;
        b.kind = k; b.data = d; b.addr = a; b.len = l; b.last = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void reply(input logic [7:0] code);
        push(KIND_TX, 8'h00, 0, 0);
        push(KIND_TX, 8'h00, 0, 0);
        push(KIND_TX, code, 0, 0);
    endfunction

    function automatic logic [31:0] word_at(input int at);
        return {m_buf[at], m_buf[at+1], m_buf[at+2], m_buf[at+3]};
    endfunction

    function automatic void finish_packet(input logic ok);
        int n;
        logic [7:0] s;
        n = int'(m_len) - 3;
        s = m_cmd;
        m_phase = PH_LEN;
        if (n > MAX_PAYLOAD) begin
            reply(NAK_CODE);
            return;
        end
        for (int i = 0; i < n; i++) s = s + m_buf[i];
        if (s != m_sum) begin
            reply(NAK_CODE);
            return;
        end
        case (m_cmd)
            CMD_PING: begin
                m_status = ST_OK;
                reply(ACK_CODE);
            end
            CMD_DOWNLOAD: begin
                m_status = ST_OK;
                if (n != 8) begin
                    m_status = ST_BAD_ARG;
                end else begin
                    m_addr = word_at(0);
                    if (m_addr != 0) begin
                        m_status = ST_BAD_ARG;
                    end else begin
                        m_addr = m_start;
                        m_remain = word_at(4);
                        push(KIND_ERASE, 8'h00, m_addr, m_remain);
                        if (!ok) m_status = ST_FLASH;
                    end
                end
                if (m_status != ST_OK) m_remain = 0;
                reply(ACK_CODE);
            end
            CMD_STATUS: begin
                reply(ACK_CODE);
                push(KIND_TX, HDR_LEN, 0, 0);
                push(KIND_TX, m_status, 0, 0);
                push(KIND_TX, m_status, 0, 0);
                m_phase = PH_STATUS_WAIT;
            end
            CMD_SEND: begin
                m_status = ST_OK;
                if (m_remain >= n) begin
                    for (int i = 0; i < n; i++) push(KIND_WRITE, m_buf[i], m_addr + i, 0);
                    if (!ok) m_status = ST_FLASH;
                    else begin
                        m_remain -= n;
                        m_addr += n;
                    end
                end else m_status = ST_RANGE;
                reply(ACK_CODE);
            end
            CMD_RESET: begin
                reply(ACK_CODE);
                push(KIND_RESET, 8'h00, 0, 0);
                m_phase = PH_HALT;
            end
            default: begin
                reply(ACK_CODE);
                m_status = ST_UNKNOWN;
            end
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic ok);
        step_beats.delete();
        case (m_phase)
            PH_HELLO_LEN: if (b == HDR_LEN) m_phase = PH_HELLO_SUM;
            PH_HELLO_SUM: m_phase = (b == CMD_PING) ? PH_HELLO_CMD : PH_HELLO_LEN;
            PH_HELLO_CMD: begin
                if (b == CMD_PING) begin
                    reply(ACK_CODE);
                    m_phase = PH_LEN;
                end else m_phase = PH_HELLO_LEN;
            end
            PH_LEN: begin
                if (b >= 3) begin
                    m_len = b;
                    m_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                m_sum = b;
                m_phase = PH_CMD;
            end
            PH_CMD: begin
                m_cmd = b;
                m_cnt = 0;
                if (m_len == 3) finish_packet(ok);
                else m_phase = PH_DATA;
            end
            PH_DATA: begin
                if (m_cnt < MAX_PAYLOAD) m_buf[m_cnt] = b;
                m_cnt = m_cnt + 1;
                if (int'(m_cnt) >= int'(m_len) - 3) finish_packet(ok);
            end
            PH_STATUS_WAIT: if (b != 0) m_phase = PH_LEN;
            default: m_phase = PH_HALT;
        endcase
        if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    endfunction

    initial begin
        rx_ch.valid = 1'b0; rx_ch.rx_byte = 8'h00; rx_ch.flash_ok = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.data = 32'h0;
        res_ch.ready = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic ok);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.flash_ok <= ok;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        predict_byte(b, ok);
        sent++;
    endtask

    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [31:0] a);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= a;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        m_start = a;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] pl [$],
                              input logic ok, input logic bad_sum);
        logic [7:0] s;
        s = cmd;
        foreach (pl[i]) s = s + pl[i];
        if (bad_sum) s = s ^ 8'h01 ^ 8'(($urandom_range(0, 127)) << 1);
        send_byte(8'(pl.size() + 3), $urandom_range(0, 1));
        send_byte(s, $urandom_range(0, 1));
        send_byte(cmd, pl.size() == 0 ? ok : logic'($urandom_range(0, 1)));
        foreach (pl[i]) send_byte(pl[i], i == pl.size() - 1 ? ok : logic'($urandom_range(0, 1)));
    endtask

    task automatic sync_greeting();
        send_byte(HDR_LEN, 1'b0);
        send_byte(CMD_PING, 1'b1);
        send_byte(CMD_PING, 1'b0);
    endtask

    task automatic send_download(input logic [31:0] hi, input logic [31:0] size, input logic ok);
        logic [7:0] pl [$];
        pl = '{hi[31:24], hi[23:16], hi[15:8], hi[7:0],
               size[31:24], size[23:16], size[15:8], size[7:0]};
        send_frame(CMD_DOWNLOAD, pl, ok, 1'b0);
    endtask

    task automatic test_directed();
        logic [7:0] pl [$];
        send_byte(8'h03, 1'b0);
        send_byte(8'h21, 1'b0);
        sync_greeting();
        send_byte(8'h00, 1'b1);
        send_byte(8'h02, 1'b0);
        send_frame(CMD_PING, pl, 1'b1, 1'b0);
        send_frame(CMD_PING, pl, 1'b1, 1'b1);
        send_download(32'h0, 32'hFFFF_FFFF, 1'b1);
        pl = '{8'hFF, 8'h00};
        send_frame(CMD_SEND, pl, 1'b1, 1'b0);
        pl = '{};
        send_frame(CMD_SEND, pl, 1'b0, 1'b0);
        send_frame(8'hFF, pl, 1'b1, 1'b0);
        send_frame(CMD_STATUS, pl, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_random();
        logic [7:0] pl [$];
        int n, sel;
        while (sent < 200) begin
            sel = $urandom_range(0, 19);
            pl = '{};
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++) pl.push_back(8'($urandom_range(0, 255)));
            case (sel)
                0, 1, 2, 3, 4, 5: send_frame(CMD_SEND, pl, $urandom_range(0, 3) != 0,
                                             $urandom_range(0, 9) == 0);
                6, 7: send_download($urandom_range(0, 7) == 0 ? $urandom : 0,
                                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
                                    $urandom_range(0, 3) != 0);
                8: send_frame(CMD_DOWNLOAD, pl, 1'b1, 1'b0);
                9, 10: send_frame(CMD_PING, pl, 1'b1, $urandom_range(0, 3) == 0);
                11: begin
                    pl = '{};
                    send_frame(CMD_STATUS, pl, 1'b1, 1'b0);
                    send_byte(8'h00, 1'b0);
                    send_byte(8'($urandom_range(1, 255)), 1'b1);
                end
                12: send_frame(8'($urandom_range(0, 255)), pl, 1'b1, 1'b0);
                13: send_byte(8'($urandom_range(0, 2)), 1'b0);
                14: begin
                    write_start($urandom);
                end
                default: send_frame(CMD_SEND, pl, 1'b1, 1'b0);
            endcase
        end
    endtask

    task automatic test_reset_halt();
        logic [7:0] pl [$];
        drain();
        pl = '{};
        send_frame(CMD_RESET, pl, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_beat got, want;
        cycles++;
        if (res_ch.valid && res_ch.ready) begin
            got.kind = t_kind'(res_ch.out_kind);
            got.data = res_ch.out_byte;
            got.addr = res_ch.out_addr;
            got.len = res_ch.out_len;
            got.last = res_ch.out_last;
            beats_seen++;
            if (pending_beats.size() == 0) begin
                report($sformatf("unexpected beat kind %0d byte %h", got.kind, got.data));
            end else begin
                want = pending_beats.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.data != want.data)
                    report($sformatf("byte %h, want %h", got.data, want.data));
                if (got.addr != want.addr)
                    report($sformatf("addr %h, want %h", got.addr, want.addr));
                if (got.len != want.len)
                    report($sformatf("len %h, want %h", got.len, want.len));
                if (got.last != want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        end
        if (cycles > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls: a random wait before each beat, with stall-free stretches.
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            w = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                res_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        m_phase = PH_HELLO_LEN;
        m_len = 0; m_sum = 0; m_cmd = 0; m_cnt = 0; m_status = ST_OK;
        m_start = 0; m_addr = 32'hFFFF_FFFF; m_remain = 0;
        foreach (m_buf[i]) m_buf[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_start(32'h0000_0000);
        test_directed();
        write_start(32'hFFFF_FFFE);
        send_download(32'h0, 32'h0000_0010, 1'b1);
        test_random();
        write_start(32'hFFFF_FFFF);
        send_download(32'h0, 32'h0000_0008, 1'b1);
        test_reset_halt();
        drain();
        $display("Sent %0d received bytes and checked %0d result beats.", sent, beats_seen);
        $display("Covered hello sync, every command, checksum and size errors, and halt.");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/sbce_pkg.sv
hw/rtl/sbce_if.sv
hw/rtl/sbce_queue.sv
hw/rtl/sbce_front.sv
hw/rtl/sbce_back.sv
hw/rtl/serial_boot_command_engine.sv
verif/serial_boot_command_engine_tb.sv
